// ===== rtl/ald_pkg.sv =====
// Shared types and constants for the analog level change detector.
package ald_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned INTERVAL_W      = 16;
  localparam int unsigned THRESH_W        = 12;
  localparam int unsigned HOLDOFF_W       = 8;
  localparam int unsigned TALLY_W         = 16;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 16;

  localparam int unsigned CUTOFF_SHIFT = 3;
  localparam int unsigned AVG_SHIFT    = 8;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd40;
  localparam logic [THRESH_W-1:0]   THRESH_RST   = 12'd24;
  localparam logic [HOLDOFF_W-1:0]  HOLDOFF_RST  = 8'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DETECT_INTERVAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_WINDOWS  = 2'd2;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_RISE = 2'd1,
    DIR_FALL = 2'd2
  } dir_e;

  typedef struct packed {
    logic fire;
    logic is_read;
    logic seed;
  } step_t;

endpackage

// ===== rtl/ald_avg.sv =====
// Running average register with seeding and outlier rejection.
module ald_avg
  import ald_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  logic                   is_read_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   seed_o,
  output logic [SAMPLE_BITS-1:0] avg_next_o
);

  localparam int unsigned SUM_W = SAMPLE_BITS + AVG_SHIFT;
  localparam int unsigned CUT_W = SAMPLE_BITS + CUTOFF_SHIFT;

  logic [SAMPLE_BITS-1:0] avg_q, avg_d;
  logic                   seeded_q, seeded_d;
  logic [CUT_W-1:0]       cutoff;
  logic [SUM_W-1:0]       sum;
  logic [SAMPLE_BITS-1:0] smoothed;

  assign cutoff   = {avg_q, {CUTOFF_SHIFT{1'b0}}};
  assign sum      = {avg_q, {AVG_SHIFT{1'b0}}} - SUM_W'(avg_q) + SUM_W'(sample_i);
  assign smoothed = (CUT_W'(sample_i) > cutoff) ? avg_q : sum[SUM_W-1:AVG_SHIFT];

  always_comb begin
    avg_d    = avg_q;
    seeded_d = seeded_q;
    if (!is_read_i) begin
      avg_d    = seeded_q ? smoothed : sample_i;
      seeded_d = 1'b1;
    end
  end

  assign seed_o     = !seeded_q;
  assign avg_next_o = avg_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q    <= '0;
      seeded_q <= 1'b0;
    end else if (fire_i) begin
      avg_q    <= avg_d;
      seeded_q <= seeded_d;
    end
  end

endmodule

// ===== rtl/ald_window.sv =====
// Window counter, holdoff, direction tracking and event tally.
module ald_window
  import ald_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  step_t                  step_i,
  input  logic [SAMPLE_BITS-1:0] avg_next_i,
  input  logic [INTERVAL_W-1:0]  interval_i,
  input  logic [THRESH_W-1:0]    thresh_i,
  input  logic [HOLDOFF_W-1:0]   holdoff_i,
  output logic [TALLY_W-1:0]     tally_o,
  output logic                   detected_o,
  output logic                   down_o
);

  localparam int unsigned CMP_W = ((SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W) + 1;

  logic [INTERVAL_W-1:0]  pos_q, pos_d;
  logic [SAMPLE_BITS-1:0] start_q, start_d, start_eff;
  logic [HOLDOFF_W-1:0]   hold_q, hold_d;
  dir_e                   dir_q, dir_d;
  logic [TALLY_W-1:0]     tally_q, tally_d;

  logic [INTERVAL_W:0] pos_inc;
  logic                win_end, rise, fall, det;
  logic [CMP_W-1:0]    avg_c, start_c, thr_c;

  assign pos_inc   = {1'b0, pos_q} + 1'b1;
  assign win_end   = pos_inc >= {1'b0, interval_i};
  assign start_eff = step_i.seed ? avg_next_i : start_q;
  assign avg_c     = CMP_W'(avg_next_i);
  assign start_c   = CMP_W'(start_eff);
  assign thr_c     = CMP_W'(thresh_i);
  assign rise      = (avg_c > start_c + thr_c) && (dir_q != DIR_RISE);
  assign fall      = (avg_c + thr_c < start_c) && (dir_q != DIR_FALL);
  assign det       = !step_i.is_read && win_end && (hold_q == '0) && (rise || fall);

  always_comb begin
    pos_d   = pos_q;
    start_d = start_q;
    hold_d  = hold_q;
    dir_d   = dir_q;
    tally_d = tally_q;
    if (step_i.is_read) begin
      tally_d = '0;
    end else begin
      start_d = start_eff;
      if (win_end) begin
        pos_d   = '0;
        start_d = avg_next_i;
        if (hold_q == '0) begin
          if (det) begin
            dir_d   = rise ? DIR_RISE : DIR_FALL;
            tally_d = tally_q + 1'b1;
            hold_d  = holdoff_i;
          end
        end else begin
          hold_d = hold_q - 1'b1;
        end
      end else begin
        pos_d = pos_inc[INTERVAL_W-1:0];
      end
    end
  end

  assign tally_o    = step_i.is_read ? tally_q : tally_d;
  assign detected_o = det;
  assign down_o     = det && fall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      start_q <= '0;
      hold_q  <= '0;
      dir_q   <= DIR_NONE;
      tally_q <= '0;
    end else if (step_i.fire) begin
      pos_q   <= pos_d;
      start_q <= start_d;
      hold_q  <= hold_d;
      dir_q   <= dir_d;
      tally_q <= tally_d;
    end
  end

endmodule

// ===== rtl/analog_level_change_detector_top.sv =====
// Top level of the analog level change detector.
//
// Each input beat is either an ADC sample (kind_i low) or a read-and-clear
// of the event count (kind_i high). Every input beat yields exactly one
// output beat carrying the running average, the event count, and the
// detection flags for that beat.
// A beat is captured in an input register and its result is computed into
// the output register when the beat advances out of the input register.
// One beat per cycle is sustained while the receiver accepts results; the
// average and window state are updated as each beat advances.
// When the receiver stalls, the result waits in the output register while
// one more beat is held in the input register; in_ready_o then drops.
// Reset clears the average, window state, event count and both registers,
// and loads the default interval, threshold and holdoff values.
// Configuration writes must be made only while no beat is in flight.
module analog_level_change_detector_top
  import ald_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   kind_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0] average_o,
  output logic [TALLY_W-1:0]     event_count_o,
  output logic                   change_detected_o,
  output logic                   went_down_o
);

  logic [INTERVAL_W-1:0] interval_q;
  logic [THRESH_W-1:0]   thresh_q;
  logic [HOLDOFF_W-1:0]  holdoff_q;

  logic                   s1_valid_q;
  logic                   s1_kind_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;
  logic                   s1_adv;

  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] avg_out_q;
  logic [TALLY_W-1:0]     cnt_out_q;
  logic                   det_out_q, down_out_q;

  step_t                  step;
  logic                   seed;
  logic [SAMPLE_BITS-1:0] avg_next;
  logic [TALLY_W-1:0]     tally;
  logic                   detected, down;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= INTERVAL_RST;
      thresh_q   <= THRESH_RST;
      holdoff_q  <= HOLDOFF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_DETECT_INTERVAL:  interval_q <= cfg_data_i[INTERVAL_W-1:0];
        REG_CHANGE_THRESHOLD: thresh_q   <= cfg_data_i[THRESH_W-1:0];
        REG_HOLDOFF_WINDOWS:  holdoff_q  <= cfg_data_i[HOLDOFF_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_kind_q   <= kind_i;
      s1_sample_q <= sample_i;
    end
  end

  assign step = '{fire: s1_adv, is_read: s1_kind_q, seed: seed};

  ald_avg #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_avg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (s1_adv),
    .is_read_i  (s1_kind_q),
    .sample_i   (s1_sample_q),
    .seed_o     (seed),
    .avg_next_o (avg_next)
  );

  ald_window #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .avg_next_i (avg_next),
    .interval_i (interval_q),
    .thresh_i   (thresh_q),
    .holdoff_i  (holdoff_q),
    .tally_o    (tally),
    .detected_o (detected),
    .down_o     (down)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      avg_out_q  <= avg_next;
      cnt_out_q  <= tally;
      det_out_q  <= detected;
      down_out_q <= down;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign average_o         = avg_out_q;
  assign event_count_o     = cnt_out_q;
  assign change_detected_o = det_out_q;
  assign went_down_o       = down_out_q;

  a_down_needs_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && went_down_o |-> change_detected_o)
    else $error("falling flag without a detected event");

  a_empty_stage_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stage empty but not ready");

  a_advance_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_o)
    else $error("advanced beat did not reach the output register");

  a_read_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_kind_q |=> !change_detected_o && !went_down_o)
    else $error("read beat reported an event");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the analog level change detector top level.
module tb;
  import ald_pkg::*;

  localparam int unsigned SB          = SAMPLE_BITS_DEF;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [SB-1:0]      average;
    logic [TALLY_W-1:0] count;
    logic               detected;
    logic               down;
  } level_result_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic                  kind_i      = 1'b0;
  logic [SB-1:0]         sample_i    = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [SB-1:0]         average_o;
  logic [TALLY_W-1:0]    event_count_o;
  logic                  change_detected_o;
  logic                  went_down_o;

  // Predicted configuration and detector state.
  logic [INTERVAL_W-1:0] cfg_interval;
  logic [THRESH_W-1:0]   cfg_thresh;
  logic [HOLDOFF_W-1:0]  cfg_holdoff;
  logic [SB-1:0]         m_avg;
  logic                  m_seeded;
  logic [SB-1:0]         m_start;
  logic [INTERVAL_W-1:0] m_pos;
  logic [HOLDOFF_W-1:0]  m_hold;
  dir_e                  m_dir;
  logic [TALLY_W-1:0]    m_tally;

  level_result_t level_q[$];
  level_result_t want_r;
  int unsigned   err_count     = 0;
  int unsigned   src_idle_pct  = 0;
  int unsigned   sink_idle_pct = 0;
  int unsigned   hold_reqs     = 0;
  int unsigned   hold_served   = 0;
  int unsigned   sink_left     = 0;

  analog_level_change_detector_top u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .sample_i          (sample_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .average_o         (average_o),
    .event_count_o     (event_count_o),
    .change_detected_o (change_detected_o),
    .went_down_o       (went_down_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic level_result_t predict_level(input logic kind, input logic [SB-1:0] smp);
    level_result_t res;
    int unsigned   lvl;
    int unsigned   start_v;
    int unsigned   thr_v;
    int unsigned   next_pos;
    logic          hit;
    res = '0;
    hit = 1'b0;
    if (kind) begin
      res.average = m_avg;
      res.count = m_tally;
      m_tally = '0;
      return res;
    end
    if (!m_seeded) begin
      m_avg = smp;
      m_start = smp;
      m_seeded = 1'b1;
    end else begin
      lvl = 32'(m_avg);
      if (smp <= (lvl << CUTOFF_SHIFT)) begin
        lvl = (((1 << AVG_SHIFT) - 1) * lvl + smp) >> AVG_SHIFT;
        m_avg = lvl[SB-1:0];
      end
    end
    next_pos = m_pos + 1;
    if (next_pos >= cfg_interval) begin
      m_pos = '0;
      if (m_hold == '0) begin
        lvl = 32'(m_avg);
        start_v = 32'(m_start);
        thr_v = 32'(cfg_thresh);
        if (lvl > start_v + thr_v && m_dir != DIR_RISE) begin
          hit = 1'b1;
          m_dir = DIR_RISE;
        end
        if (lvl + thr_v < start_v && m_dir != DIR_FALL) begin
          hit = 1'b1;
          m_dir = DIR_FALL;
        end
        if (hit) begin
          m_tally = m_tally + 1'b1;
          m_hold = cfg_holdoff;
          res.down = (m_dir == DIR_FALL);
        end
      end else begin
        m_hold = m_hold - 1'b1;
      end
      m_start = m_avg;
    end else begin
      m_pos = next_pos[INTERVAL_W-1:0];
    end
    res.average = m_avg;
    res.count = m_tally;
    res.detected = hit;
    return res;
  endfunction

  task automatic send_beat(input logic kind, input logic [SB-1:0] smp);
    int unsigned pause;
    if ($urandom_range(0, 99) < src_idle_pct) begin
      pause = idle_len();
      in_valid_i <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    sample_i <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    level_q.push_back(predict_level(kind, smp));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (level_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_DETECT_INTERVAL:  cfg_interval = data;
      REG_CHANGE_THRESHOLD: cfg_thresh = data[THRESH_W-1:0];
      REG_HOLDOFF_WINDOWS:  cfg_holdoff = data[HOLDOFF_W-1:0];
      default: ;
    endcase
  endtask

  // Upper data bits above the threshold and holdoff register widths are randomized and must be dropped.
  task automatic apply_config(input logic [INTERVAL_W-1:0] iv, input logic [THRESH_W-1:0] th,
                              input logic [HOLDOFF_W-1:0] ho);
    logic [31:0]                     rnd;
    logic [CFG_DATA_W-THRESH_W-1:0]  th_hi;
    logic [CFG_DATA_W-HOLDOFF_W-1:0] ho_hi;
    rnd = $urandom;
    th_hi = rnd[CFG_DATA_W-THRESH_W-1:0];
    rnd = $urandom;
    ho_hi = rnd[CFG_DATA_W-HOLDOFF_W-1:0];
    drain();
    cfg_write(REG_DETECT_INTERVAL, iv);
    cfg_write(REG_CHANGE_THRESHOLD, {th_hi, th});
    cfg_write(REG_HOLDOFF_WINDOWS, {ho_hi, ho});
  endtask

  task automatic test_reset_state();
    send_beat(1'b1, 12'hABC);
    send_beat(1'b0, '1);
    send_beat(1'b0, '0);
    send_beat(1'b0, '1);
    send_beat(1'b0, 12'h555);
    send_beat(1'b0, 12'hAAA);
    send_beat(1'b1, '0);
  endtask

  task automatic test_register_extremes();
    // A threshold above the window start average must not wrap the fall test.
    apply_config('0, '1, '1);
    repeat (3) send_beat(1'b0, '0);
    drain();
    cfg_write(REG_UNUSED, '1);
    repeat (2) send_beat(1'b0, 12'h7FF);
    apply_config('1, '0, '0);
    repeat (3) send_beat(1'b0, 12'hF00);
  endtask

  task automatic test_window_rules();
    apply_config(16'd4, 12'd2, 8'd2);
    repeat (16) send_beat(1'b0, '0);
    repeat (8) send_beat(1'b0, '1);
    apply_config(16'd20, 12'd8, 8'd0);
    repeat (5) send_beat(1'b0, 12'h800);
    apply_config(16'd3, 12'd8, 8'd0);
    send_beat(1'b0, 12'h800);
    send_beat(1'b1, '0);
  endtask

  task automatic test_event_burst();
    int unsigned n;
    src_idle_pct = 0;
    sink_idle_pct <= 0;
    apply_config('0, '0, '0);
    while (m_avg > 3000) send_beat(1'b0, '0);
    for (n = 0; n < 80; n++) send_beat(1'b0, n[0] ? '0 : '1);
    send_beat(1'b1, '0);
    drain();
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_idle_pct <= 0;
    apply_config(16'd2, 12'd16, 8'd1);
    hold_reqs <= hold_reqs + 1;
    repeat (40) send_beat($urandom_range(0, 9) == 0, SB'($urandom_range(1500, 2500)));
    drain();
  endtask

  task automatic test_random_levels();
    int unsigned phase;
    int unsigned done;
    int unsigned r;
    int unsigned target;
    int unsigned len;
    int unsigned lvl;
    logic [INTERVAL_W-1:0] iv;
    logic [THRESH_W-1:0]   th;
    logic [HOLDOFF_W-1:0]  ho;
    logic [SB-1:0]         smp;
    for (phase = 0; phase < 6; phase++) begin
      r = $urandom_range(0, 99);
      iv = (r < 10) ? 16'd0 : (r < 20) ? 16'd1 : (r < 24) ? 16'hFFFF :
           INTERVAL_W'($urandom_range(2, 48));
      r = $urandom_range(0, 99);
      th = (r < 10) ? 12'd0 : (r < 15) ? 12'hFFF : THRESH_W'($urandom_range(0, 120));
      r = $urandom_range(0, 99);
      ho = (r < 15) ? 8'd0 : (r < 20) ? 8'hFF : HOLDOFF_W'($urandom_range(1, 4));
      apply_config(iv, th, ho);
      src_idle_pct = (phase % 3 == 0) ? 0 : $urandom_range(10, 40);
      sink_idle_pct <= (phase % 4 == 1) ? 0 : $urandom_range(10, 40);
      done = 0;
      while (done < 50) begin
        r = $urandom_range(0, 99);
        target = (r < 10) ? $urandom_range(0, 4095) : $urandom_range(256, 4095);
        len = $urandom_range(8, 60);
        repeat (len) begin
          r = $urandom_range(0, 99);
          smp = SB'($urandom);
          if (r < 5) begin
            send_beat(1'b1, smp);
          end else begin
            if (r >= 10) begin
              lvl = target + $urandom_range(0, 32);
              lvl = (lvl < 16) ? 0 : lvl - 16;
              smp = (lvl > 4095) ? '1 : lvl[SB-1:0];
            end
            send_beat(1'b0, smp);
          end
          done++;
        end
      end
    end
    drain();
  endtask

  // Once the average reaches zero it can never leave it, so this runs last.
  task automatic test_zero_average();
    int unsigned guard;
    src_idle_pct = 0;
    sink_idle_pct <= 0;
    apply_config(16'd1, 12'd0, 8'd0);
    guard = 0;
    while (m_avg != '0 && guard < 4000) begin
      send_beat(1'b0, '0);
      guard++;
    end
    send_beat(1'b0, '1);
    send_beat(1'b0, 12'd1);
    send_beat(1'b0, 12'h800);
    send_beat(1'b0, '0);
    send_beat(1'b1, '0);
  endtask

  always @(posedge clk_i) begin
    if (hold_reqs != hold_served) begin
      hold_served <= hold_reqs;
      sink_left <= LONG_HOLD;
      out_ready_i <= 1'b0;
    end else if (sink_left != 0) begin
      sink_left <= sink_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 99) < sink_idle_pct) begin
      sink_left <= idle_len() - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (level_q.size() == 0) begin
        err_count++;
        $error("unexpected result beat: average %0d, event_count %0d", average_o, event_count_o);
      end else begin
        want_r = level_q.pop_front();
        if (average_o !== want_r.average) begin
          err_count++;
          $error("average: expected %0d, got %0d", want_r.average, average_o);
        end
        if (event_count_o !== want_r.count) begin
          err_count++;
          $error("event_count: expected %0d, got %0d", want_r.count, event_count_o);
        end
        if (change_detected_o !== want_r.detected) begin
          err_count++;
          $error("change_detected: expected %0d, got %0d", want_r.detected, change_detected_o);
        end
        if (went_down_o !== want_r.down) begin
          err_count++;
          $error("went_down: expected %0d, got %0d", want_r.down, went_down_o);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    cfg_interval = INTERVAL_RST;
    cfg_thresh = THRESH_RST;
    cfg_holdoff = HOLDOFF_RST;
    m_avg = '0;
    m_seeded = 1'b0;
    m_start = '0;
    m_pos = '0;
    m_hold = '0;
    m_dir = DIR_NONE;
    m_tally = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    src_idle_pct = 20;
    sink_idle_pct <= 20;
    test_reset_state();
    test_register_extremes();
    test_window_rules();
    test_event_burst();
    test_backpressure();
    test_random_levels();
    test_zero_average();
    drain();
    if (err_count == 0 && level_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
